// File: rtl/core/sps_pkg.sv
// sps_pkg: shared types and constants for the sensor poll sequencer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package sps_pkg;

   // Timing of one second and sensor population
   localparam int unsigned TICKS_PER_SEC = 100;   // 4 .. 128
   localparam int unsigned TEMP_SENSORS  = 3;     // 1 .. 3

   localparam int unsigned PHASE_W = 7;
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SEC - 1);

   // Fixed humidity read phases, one per sensor
   localparam logic [PHASE_W-1:0] HUMID_PHASE_1 = PHASE_W'(20);
   localparam logic [PHASE_W-1:0] HUMID_PHASE_2 = PHASE_W'(53);
   localparam logic [PHASE_W-1:0] HUMID_PHASE_3 = PHASE_W'(86);

   localparam logic [2:0] TEMP_MASK_LIMIT = 3'((1 << TEMP_SENSORS) - 1);

   localparam logic [7:0] OPT_MAX    = 8'd255;
   localparam logic [5:0] PRESS_MAX  = 6'd63;
   localparam logic [7:0] ABSENT_MAX = 8'd255;

   // Register file
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BARO_MASK   = 3'd0,
      CSR_HUMID_MASK  = 3'd1,
      CSR_TEMP_MASK   = 3'd2,
      CSR_ABSENT_LIM  = 3'd3,
      CSR_TRIG_PHASE  = 3'd4,
      CSR_SLOW_PHASE  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [3:0]         baro_present_mask;
      logic [2:0]         humid_present_mask;
      logic [2:0]         temp_present_mask;
      logic [7:0]         absent_limit;
      logic [PHASE_W-1:0] temp_trigger_phase;
      logic [PHASE_W-1:0] slow_read_phase;
   } cfg_type;

   typedef enum logic [1:0] {
      START_NONE  = 2'd0,
      START_PRESS = 2'd1,
      START_TEMP  = 2'd2
   } start_kind_type;

   typedef enum logic [1:0] {
      HUMID_NONE = 2'd0,
      HUMID_S1   = 2'd1,
      HUMID_S2   = 2'd2,
      HUMID_S3   = 2'd3
   } humid_sel_type;

   typedef enum logic [1:0] {
      SHUT_NONE   = 2'd0,
      SHUT_ENTER  = 2'd1,
      SHUT_RESUME = 2'd2
   } shut_type;

   typedef struct packed {
      logic ppg_read_ok;
      logic baro_finish_ok;
      logic baro_start_ok;
      logic wearer_present;
      logic second_boundary;
   } req_word_type;

   typedef struct packed {
      logic           ppg_read;
      logic           baro_finish;
      start_kind_type baro_start_kind;
      humid_sel_type  humid_select;
      logic           temp_trigger;
      logic [2:0]     temp_read_mask;
      logic           slow_sample;
      shut_type       shutdown_change;
      logic           standby_now;
      logic           rate_update;
      logic [7:0]     optical_rate;
      logic [5:0]     pressure_rate;
   } rsp_word_type;

endpackage

// File: rtl/core/sps_req_if.sv
// sps_req_if / sps_rsp_if: valid/ready channels for tick words and result words.
// Depends on sps_pkg for the payload types.
`timescale 1ns / 1ps

interface sps_req_if import sps_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sps_csr.sv
// sps_csr: configuration registers of the sequencer, write-only port.
// Depends on sps_pkg (cfg_type, register indexes).
`timescale 1ns / 1ps

module sps_csr import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BARO_MASK:  cfg_in.baro_present_mask  = csr_wdata[3:0];
            CSR_HUMID_MASK: cfg_in.humid_present_mask = csr_wdata[2:0];
            CSR_TEMP_MASK:  cfg_in.temp_present_mask  = csr_wdata[2:0];
            CSR_ABSENT_LIM: cfg_in.absent_limit       = csr_wdata[7:0];
            CSR_TRIG_PHASE: cfg_in.temp_trigger_phase = csr_wdata[PHASE_W-1:0];
            CSR_SLOW_PHASE: cfg_in.slow_read_phase    = csr_wdata[PHASE_W-1:0];
            default: ;  // unmapped index: write is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baro_present_mask  <= 4'd15;
         cfg_ff.humid_present_mask <= 3'd7;
         cfg_ff.temp_present_mask  <= 3'd7;
         cfg_ff.absent_limit       <= 8'd5;
         cfg_ff.temp_trigger_phase <= PHASE_W'(40);
         cfg_ff.slow_read_phase    <= PHASE_W'(70);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/sps_core.sv
// sps_core: sequencer state and the per-tick action decode.
// Depends on sps_pkg. State advances once per word moved to the result register.
`timescale 1ns / 1ps

module sps_core import sps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_word_type tick,
   input  cfg_type      cfg,
   output rsp_word_type result
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [1:0]         quarter_ff, quarter_in;
   logic               pending_ff, pending_in;
   logic               want_temp_ff, want_temp_in;
   logic               standby_ff, standby_in;
   logic [7:0]         absent_ff, absent_in;
   logic [7:0]         optical_ff, optical_in;
   logic [5:0]         pressure_ff, pressure_in;

   logic       baro_slot;
   logic       slow_hit;
   logic [7:0] absent_inc;
   logic [7:0] optical_next;
   logic [5:0] pressure_next;

   always_comb begin
      result       = '0;
      standby_in   = standby_ff;
      absent_in    = absent_ff;
      pending_in   = pending_ff;
      want_temp_in = want_temp_ff;

      baro_slot = !standby_ff && (cfg.baro_present_mask != 4'd0) && (quarter_ff == 2'd0);
      slow_hit  = (phase_ff == cfg.slow_read_phase);

      optical_next = optical_ff;
      if (!standby_ff && tick.ppg_read_ok && optical_ff != OPT_MAX)
         optical_next = optical_ff + 8'd1;

      pressure_next = pressure_ff;
      if (baro_slot && pending_ff && tick.baro_finish_ok && pressure_ff != PRESS_MAX)
         pressure_next = pressure_ff + 6'd1;

      result.ppg_read    = !standby_ff;
      result.baro_finish = baro_slot && pending_ff;
      if (baro_slot) begin
         result.baro_start_kind = want_temp_ff ? START_TEMP : START_PRESS;
         pending_in             = tick.baro_start_ok;
         want_temp_in           = 1'b0;
      end

      if (!standby_ff) begin
         priority if (phase_ff == HUMID_PHASE_1 && cfg.humid_present_mask[0])
            result.humid_select = HUMID_S1;
         else if (phase_ff == HUMID_PHASE_2 && cfg.humid_present_mask[1])
            result.humid_select = HUMID_S2;
         else if (phase_ff == HUMID_PHASE_3 && cfg.humid_present_mask[2])
            result.humid_select = HUMID_S3;
         else
            result.humid_select = HUMID_NONE;
         result.temp_trigger = (phase_ff == cfg.temp_trigger_phase);
      end

      // presence check and standby entry/exit at the slow phase
      absent_inc = (absent_ff != ABSENT_MAX) ? absent_ff + 8'd1 : absent_ff;
      if (slow_hit) begin
         result.slow_sample = 1'b1;
         if (!standby_ff)
            result.temp_read_mask = cfg.temp_present_mask & TEMP_MASK_LIMIT;
         if (tick.wearer_present) begin
            absent_in = 8'd0;
            if (standby_ff) begin
               standby_in             = 1'b0;
               result.shutdown_change = SHUT_RESUME;
            end
         end else if (!standby_ff) begin
            absent_in = absent_inc;
            if (absent_inc >= cfg.absent_limit) begin
               standby_in             = 1'b1;
               result.shutdown_change = SHUT_ENTER;
            end
         end
      end
      result.standby_now = standby_in;

      phase_in   = (phase_ff == PHASE_LAST) ? '0 : phase_ff + PHASE_W'(1);
      quarter_in = quarter_ff + 2'd1;

      optical_in  = optical_next;
      pressure_in = pressure_next;
      if (tick.second_boundary) begin
         result.rate_update   = 1'b1;
         result.optical_rate  = optical_next;
         result.pressure_rate = pressure_next;
         optical_in           = 8'd0;
         pressure_in          = 6'd0;
         want_temp_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         quarter_ff   <= 2'd0;
         pending_ff   <= 1'b0;
         want_temp_ff <= 1'b0;
         standby_ff   <= 1'b0;
         absent_ff    <= 8'd0;
         optical_ff   <= 8'd0;
         pressure_ff  <= 6'd0;
      end else if (advance) begin
         phase_ff     <= phase_in;
         quarter_ff   <= quarter_in;
         pending_ff   <= pending_in;
         want_temp_ff <= want_temp_in;
         standby_ff   <= standby_in;
         absent_ff    <= absent_in;
         optical_ff   <= optical_in;
         pressure_ff  <= pressure_in;
      end
   end

endmodule

// File: rtl/core/sensor_poll_sequencer.sv
// sensor_poll_sequencer: top level; input register, decode core, result register.
// Depends on sps_pkg, sps_req_if/sps_rsp_if, sps_csr and sps_core.
//
//   port  | dir | handshake        | word
//   ------+-----+------------------+-------------------------------------
//   req   | in  | valid/ready      | one 10 ms tick event (5 flags)
//   rsp   | out | valid/ready      | actions due in that tick, rates
//   csr   | in  | wr_en, no ready  | index 0..5, 8-bit data
//
// A word accepted at req moves from the input register to the result register
// once it is empty or being read; one word per cycle sustained while rsp
// stays ready. The input register feeds the decode, whose state updates as
// the word lands in the result register. A stalled rsp holds its word; the
// input register still takes one more word. Reset (synchronous) clears both
// registers' valid bits, the sequencer state and loads the register defaults.
`timescale 1ns / 1ps

module sensor_poll_sequencer import sps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sps_req_if.sink               req,
   sps_rsp_if.source             rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   rsp_word_type result;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;

   logic out_free;
   logic advance;
   logic req_take;

   sps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sps_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .tick    (in_word_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take)
         in_word_ff <= req.data;
      if (advance)
         out_word_ff <= result;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_word_ff;

   // input register must hold while the result side is blocked
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |-> !req.ready)
      else $error("input register overwritten while result stage blocked");

   a_finish_has_start: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.baro_finish) |-> (rsp.data.baro_start_kind != START_NONE))
      else $error("pressure finish without a following start");

   a_enter_sets_standby: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.shutdown_change == SHUT_ENTER)
         |-> (rsp.data.standby_now && rsp.data.ppg_read))
      else $error("standby entry inconsistent with flags");

   a_rates_only_published: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.data.rate_update)
         |-> (rsp.data.optical_rate == 8'd0 && rsp.data.pressure_rate == 6'd0))
      else $error("rates nonzero outside a second boundary");

   a_result_follows_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp.valid)
      else $error("advanced word did not appear at the result port");

endmodule
